### design/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types, codes and sizing constants of the lifo stack allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

  // record stack sizing
  localparam int MAX_RECORDS = 64;
  localparam int REC_IDX_W   = $clog2(MAX_RECORDS);
  localparam int REC_CNT_W   = REC_IDX_W + 1;

  // region geometry
  localparam int ADDR_BITS     = 20;
  localparam int HEADER_BYTES  = 16;
  localparam int HEADER_ALIGN  = 8;
  localparam int BACKPTR_BYTES = 8;

  // field widths
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int SIZE_W  = 21;
  localparam int ALIGN_W = 13;
  localparam int OFF_W   = ADDR_BITS;
  localparam int TOP_W   = ADDR_BITS + 1;
  localparam int SUM_W   = ADDR_BITS + 2;
  localparam int CAP_W   = 21;
  localparam int CNT_W   = 32;
  localparam int REC_W   = OFF_W + SIZE_W + TOP_W;

  localparam logic [TOP_W-1:0] CAP_LIMIT  = TOP_W'(1) << ADDR_BITS;
  localparam logic [SUM_W-1:0] HDR_PAD    = SUM_W'(HEADER_ALIGN - 1);
  localparam logic [SUM_W-1:0] HDR_EXTRA  = SUM_W'(HEADER_BYTES + BACKPTR_BYTES);
  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(65536);

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_RESET_TOP = 2'd2,
    OP_CLR_STATS = 2'd3
  } lsa_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK            = 3'd0,
    ST_ZERO_SIZE     = 3'd1,
    ST_BAD_ALIGN     = 3'd2,
    ST_NO_MEM        = 3'd3,
    ST_NOT_OWNED     = 3'd4,
    ST_SIZE_MISMATCH = 3'd5,
    ST_LIFO          = 3'd6,
    ST_FULL          = 3'd7
  } lsa_status_e;

  typedef struct packed {
    logic [OFF_W-1:0]  data;
    logic [SIZE_W-1:0] size;
    logic [TOP_W-1:0]  prev;
  } lsa_record_t;

  typedef struct packed {
    logic                 we;
    logic [REC_IDX_W-1:0] waddr;
    lsa_record_t          wdata;
    logic                 re;
    logic [REC_IDX_W-1:0] raddr;
  } lsa_mem_req_t;

  typedef struct packed {
    lsa_status_e      status;
    logic [OFF_W-1:0] data_offset;
    logic [TOP_W-1:0] used_bytes;
    logic [TOP_W-1:0] remaining_bytes;
    logic [TOP_W-1:0] peak_bytes;
    logic [CNT_W-1:0] alloc_total;
    logic [CNT_W-1:0] free_total;
    logic [CNT_W-1:0] active_total;
  } lsa_result_t;

endpackage

### design/lifo_stack_allocator.sv
// ----------------------------------------------------------------------------
// lifo_stack_allocator
// Stack allocator over a byte region with a LIFO record stack in RAM.
// ----------------------------------------------------------------------------
// Requests (allocate, free, reset top, clear statistics) arrive on a
// valid/ready input channel; each produces exactly one result transaction
// on a valid/ready output channel carrying status, data offset, usage and
// the allocation counters. The region capacity is set through an APB-style
// register at address 0 (reset value 65536); it must be changed only while
// idle, which the block itself does not enforce. One request is processed
// at a time, and the next can be accepted in the same cycle that the
// previous result appears. Reset top, clear statistics and a free rejected
// before the search produce their result directly; an allocate is checked
// for size, alignment and capacity, then, unless the record stack is empty,
// examines the top records (the stale records dropped, plus one unless every
// record was stale); a free searches the records from the newest down.
// The record RAM read port, one record per cycle, sets the scan rate.
// A new request is taken while the previous result still waits in the
// output register; a stalled receiver blocks the block only once the next
// result is ready. Reset empties the record stack, zeroes top, peak and
// counters, and leaves the record RAM contents undefined.
module lifo_stack_allocator
  import lsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    opcode_i,
  input  logic [SIZE_W-1:0]  request_size_i,
  input  logic [ALIGN_W-1:0] alignment_i,
  input  logic [OFF_W-1:0]   free_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [OFF_W-1:0]   data_offset_o,
  output logic [TOP_W-1:0]   used_bytes_o,
  output logic [TOP_W-1:0]   remaining_bytes_o,
  output logic [TOP_W-1:0]   peak_bytes_o,
  output logic [CNT_W-1:0]   alloc_total_o,
  output logic [CNT_W-1:0]   free_total_o,
  output logic [CNT_W-1:0]   active_total_o
);

  logic [CAP_W-1:0] capacity;
  lsa_mem_req_t     mem_req;
  lsa_record_t      rd_data;
  logic [REC_W-1:0] rd_raw;
  lsa_result_t      result;

  lsa_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  lsa_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_raw)
  );

  assign rd_data = lsa_record_t'(rd_raw);

  lsa_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .request_size_i (request_size_i),
    .alignment_i    (alignment_i),
    .free_offset_i  (free_offset_i),
    .capacity_i     (capacity),
    .mem_req_o      (mem_req),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result)
  );

  assign status_o          = result.status;
  assign data_offset_o     = result.data_offset;
  assign used_bytes_o      = result.used_bytes;
  assign remaining_bytes_o = result.remaining_bytes;
  assign peak_bytes_o      = result.peak_bytes;
  assign alloc_total_o     = result.alloc_total;
  assign free_total_o      = result.free_total;
  assign active_total_o    = result.active_total;

endmodule

### design/lsa_ram.sv
// ----------------------------------------------------------------------------
// lsa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lsa_apb_regs.sv
// ----------------------------------------------------------------------------
// lsa_apb_regs
// APB-style configuration register file holding the region capacity.
// ----------------------------------------------------------------------------
module lsa_apb_regs
  import lsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CAP_W-1:0]   capacity_o
);

  logic [CAP_W-1:0]     capacity_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (wr_en && (reg_idx == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      prdata = PDATA_W'(capacity_q);
    end
  end

  assign capacity_o = capacity_q;

endmodule

### design/lsa_core.sv
// ----------------------------------------------------------------------------
// lsa_core
// Request sequencer: offset arithmetic, record stack scan and update over the
// record RAM, allocator state and the result register.
// ----------------------------------------------------------------------------
module lsa_core
  import lsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    opcode_i,
  input  logic [SIZE_W-1:0]  request_size_i,
  input  logic [ALIGN_W-1:0] alignment_i,
  input  logic [OFF_W-1:0]   free_offset_i,
  input  logic [CAP_W-1:0]   capacity_i,
  output lsa_mem_req_t       mem_req_o,
  input  lsa_record_t        rd_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lsa_result_t        result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIT,
    S_SCAN,
    S_OUT
  } state_e;

  state_e               state_q, state_d;
  lsa_op_e              op_q, op_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [ALIGN_W-1:0]   align_q, align_d;
  logic [OFF_W-1:0]     off_q, off_d;
  logic [TOP_W-1:0]     top_q, top_d;
  logic [TOP_W-1:0]     peak_q, peak_d;
  logic [CNT_W-1:0]     alloc_cnt_q, alloc_cnt_d;
  logic [CNT_W-1:0]     free_cnt_q, free_cnt_d;
  logic [REC_CNT_W-1:0] rec_cnt_q, rec_cnt_d;
  logic [SUM_W-1:0]     data_q, data_d;
  lsa_status_e          status_q, status_d;
  logic [OFF_W-1:0]     dout_q, dout_d;
  logic [REC_IDX_W-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  lsa_result_t          out_q, out_d;

  logic [TOP_W-1:0]     eff_cap;
  logic [SUM_W-1:0]     cap_ext;
  logic [SUM_W-1:0]     top_ext;
  logic [SUM_W-1:0]     hdr_base;
  logic [ALIGN_W-1:0]   align_m1;
  logic [SUM_W-1:0]     amask;
  logic [SUM_W-1:0]     data_calc;
  logic [SUM_W-1:0]     newtop;
  logic                 bad_align;
  logic [SUM_W-1:0]     rec_end;
  logic [SUM_W-1:0]     free_end;
  logic [REC_IDX_W-1:0] top_rec_idx;
  logic                 push_en;
  logic [REC_IDX_W-1:0] push_idx;
  lsa_mem_req_t         mem_req;

  // capacity in use is limited to the addressable region
  assign eff_cap = (TOP_W'(capacity_i) > CAP_LIMIT) ? CAP_LIMIT : TOP_W'(capacity_i);
  assign cap_ext = SUM_W'(eff_cap);
  assign top_ext = SUM_W'(top_q);

  // header aligned slot plus back pointer, then data aligned up
  assign hdr_base  = ((top_ext + HDR_PAD) & ~HDR_PAD) + HDR_EXTRA;
  assign align_m1  = align_q - ALIGN_W'(1);
  assign amask     = SUM_W'(align_m1);
  assign data_calc = (hdr_base + amask) & ~amask;
  assign newtop    = data_q + SUM_W'(size_q);
  assign bad_align = (align_q == '0) || ((align_q & align_m1) != '0);

  assign rec_end     = SUM_W'(rd_data_i.data) + SUM_W'(rd_data_i.size);
  assign free_end    = SUM_W'(off_q) + SUM_W'(size_q);
  assign top_rec_idx = REC_IDX_W'(rec_cnt_q - REC_CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    size_d      = size_q;
    align_d     = align_q;
    off_d       = off_q;
    top_d       = top_q;
    peak_d      = peak_q;
    alloc_cnt_d = alloc_cnt_q;
    free_cnt_d  = free_cnt_q;
    rec_cnt_d   = rec_cnt_q;
    data_d      = data_q;
    status_d    = status_q;
    dout_d      = dout_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    push_en     = 1'b0;
    push_idx    = '0;
    mem_req     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = lsa_op_e'(opcode_i);
          size_d   = request_size_i;
          align_d  = alignment_i;
          off_d    = free_offset_i;
          status_d = ST_OK;
          dout_d   = '0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_q)
          OP_ALLOC: begin
            data_d  = data_calc;
            state_d = S_FIT;
          end
          OP_FREE: begin
            if ((eff_cap == '0) || (TOP_W'(off_q) >= eff_cap) || (rec_cnt_q == '0)) begin
              status_d = ST_NOT_OWNED;
              state_d  = S_OUT;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = top_rec_idx;
              idx_d         = top_rec_idx;
              state_d       = S_SCAN;
            end
          end
          OP_RESET_TOP: begin
            top_d   = '0;
            state_d = S_OUT;
          end
          OP_CLR_STATS: begin
            peak_d      = top_q;
            alloc_cnt_d = '0;
            free_cnt_d  = '0;
            state_d     = S_OUT;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end

      S_FIT: begin
        if (size_q == '0) begin
          status_d = ST_ZERO_SIZE;
          state_d  = S_OUT;
        end else if (bad_align) begin
          status_d = ST_BAD_ALIGN;
          state_d  = S_OUT;
        end else if ((eff_cap == '0) || (newtop > cap_ext)) begin
          status_d = ST_NO_MEM;
          state_d  = S_OUT;
        end else if (rec_cnt_q == '0) begin
          push_en  = 1'b1;
          push_idx = '0;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = top_rec_idx;
          idx_d         = top_rec_idx;
          state_d       = S_SCAN;
        end
      end

      S_SCAN: begin
        if (op_q == OP_ALLOC) begin
          // drop records left beyond the top by a top reset
          if (rec_end > top_ext) begin
            if (idx_q == '0) begin
              push_en  = 1'b1;
              push_idx = '0;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = idx_q - REC_IDX_W'(1);
              idx_d         = idx_q - REC_IDX_W'(1);
            end
          end else if (idx_q == REC_IDX_W'(MAX_RECORDS - 1)) begin
            status_d = ST_FULL;
            state_d  = S_OUT;
          end else begin
            push_en  = 1'b1;
            push_idx = idx_q + REC_IDX_W'(1);
          end
        end else begin
          // newest-first search for the freed offset
          if (rd_data_i.data == off_q) begin
            if (rd_data_i.size != size_q) begin
              status_d = ST_SIZE_MISMATCH;
            end else if (free_end > top_ext) begin
              status_d = ST_LIFO;
            end else begin
              top_d      = rd_data_i.prev;
              rec_cnt_d  = REC_CNT_W'(idx_q);
              free_cnt_d = free_cnt_q + CNT_W'(1);
            end
            state_d = S_OUT;
          end else if (idx_q == '0) begin
            status_d = ST_NOT_OWNED;
            state_d  = S_OUT;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_q - REC_IDX_W'(1);
            idx_d         = idx_q - REC_IDX_W'(1);
          end
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.status          = status_q;
          out_d.data_offset     = dout_q;
          out_d.used_bytes      = top_q;
          out_d.remaining_bytes = (eff_cap > top_q) ? (eff_cap - top_q) : '0;
          out_d.peak_bytes      = peak_q;
          out_d.alloc_total     = alloc_cnt_q;
          out_d.free_total      = free_cnt_q;
          out_d.active_total    = alloc_cnt_q - free_cnt_q;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push_en) begin
      mem_req.we         = 1'b1;
      mem_req.waddr      = push_idx;
      mem_req.wdata.data = data_q[OFF_W-1:0];
      mem_req.wdata.size = size_q;
      mem_req.wdata.prev = top_q;
      rec_cnt_d          = REC_CNT_W'(push_idx) + REC_CNT_W'(1);
      top_d              = newtop[TOP_W-1:0];
      if (newtop[TOP_W-1:0] > peak_q) begin
        peak_d = newtop[TOP_W-1:0];
      end
      alloc_cnt_d = alloc_cnt_q + CNT_W'(1);
      dout_d      = data_q[OFF_W-1:0];
      status_d    = ST_OK;
      state_d     = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ALLOC;
      size_q      <= '0;
      align_q     <= '0;
      off_q       <= '0;
      top_q       <= '0;
      peak_q      <= '0;
      alloc_cnt_q <= '0;
      free_cnt_q  <= '0;
      rec_cnt_q   <= '0;
      data_q      <= '0;
      status_q    <= ST_OK;
      dout_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      size_q      <= size_d;
      align_q     <= align_d;
      off_q       <= off_d;
      top_q       <= top_d;
      peak_q      <= peak_d;
      alloc_cnt_q <= alloc_cnt_d;
      free_cnt_q  <= free_cnt_d;
      rec_cnt_q   <= rec_cnt_d;
      data_q      <= data_d;
      status_q    <= status_d;
      dout_q      <= dout_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign mem_req_o   = mem_req;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule
